/* rtl/core/gcr_pkg.sv */
// ----------------------------------------------------------------------------
// gcr_pkg - shared definitions for the group receive scoreboard
// Sizes, command and status codes, and the request passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

    localparam int WINDOW      = 64;
    localparam int RCV_WINDOW  = 128;
    localparam int CONTEXTS    = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int SEQ_W    = 16;
    localparam int ADDR_W   = 48;
    localparam int BITMAP_W = 64;
    localparam int STATUS_W = 3;
    localparam int SEQ_SPACE = 65536;

    localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int AMT_W = $clog2(RCV_WINDOW + 1);
    localparam int OFF_W = $clog2(RCV_WINDOW);

    localparam logic [SEQ_W-1:0] SEQ_TOP2  = SEQ_W'(SEQ_SPACE - 2 * WINDOW);
    localparam logic [SEQ_W-1:0] SEQ_TOP1  = SEQ_W'(SEQ_SPACE - WINDOW);
    localparam logic [SEQ_W-1:0] WIN_SEQ   = SEQ_W'(WINDOW);
    localparam logic [SEQ_W-1:0] ALIGN_MSK = ~SEQ_W'(WINDOW - 1);

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_BAR  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_RECORDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CREATED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BA_SENT     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAR_IGNORED = 3'd5;

    typedef enum logic [2:0] {
        OP_DATA     = 3'd0,
        OP_CREATE   = 3'd1,
        OP_FULL     = 3'd2,
        OP_BAR      = 3'd3,
        OP_BAR_MISS = 3'd4
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CTX_W-1:0]  idx;
        logic [SEQ_W-1:0]  num;   // seq_num for data, bar_start for BAR
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

/* rtl/core/gcr_front.sv */
// ----------------------------------------------------------------------------
// gcr_front - source lookup and request classification
// Owns the context valid bits and source addresses; allocates new contexts.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_front
    import gcr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              cmd,
    input  wire logic [ADDR_W-1:0] src_addr,
    input  wire logic [SEQ_W-1:0]  seq_num,
    input  wire logic [SEQ_W-1:0]  bar_start,
    input  wire q_status_t         q_status,
    output logic                   busy,
    output logic                   push,
    output req_t                   push_req
);

    logic [CONTEXTS-1:0] valid_reg;
    logic [CONTEXTS-1:0] valid_next;
    logic [ADDR_W-1:0]   source_reg [CONTEXTS];

    logic                hit_any;
    logic [CTX_W-1:0]    hit_idx;
    logic                free_any;
    logic [CTX_W-1:0]    free_idx;

    // lowest matching and lowest free entry
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int k = CONTEXTS - 1; k >= 0; k--)
        begin
            if (valid_reg[k] && (source_reg[k] == src_addr))
            begin
                hit_any = 1'b1;
                hit_idx = CTX_W'(k);
            end
            if (!valid_reg[k])
            begin
                free_any = 1'b1;
                free_idx = CTX_W'(k);
            end
        end
    end

    always_comb
    begin
        push_req.num = (cmd == CMD_BAR) ? bar_start : seq_num;
        push_req.idx = hit_any ? hit_idx : free_idx;
        if (cmd == CMD_BAR)
            push_req.op = hit_any ? OP_BAR : OP_BAR_MISS;
        else if (hit_any)
            push_req.op = OP_DATA;
        else if (free_any)
            push_req.op = OP_CREATE;
        else
            push_req.op = OP_FULL;
    end

    assign busy = q_status.full;
    assign push = start && !busy;

    always_comb
    begin
        valid_next = valid_reg;
        if (push && (push_req.op == OP_CREATE))
            valid_next[free_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push && (push_req.op == OP_CREATE))
            source_reg[free_idx] <= src_addr;
    end

endmodule

`default_nettype wire

/* rtl/core/gcr_queue.sv */
// ----------------------------------------------------------------------------
// gcr_queue - short request queue between front and back
// Fall-through FIFO of classified requests.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_queue
    import gcr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire req_t push_req,
    input  wire logic pop,
    output req_t      head,
    output q_status_t q_status
);

    localparam int QD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t             mem [QUEUE_DEPTH];
    logic [QD_W-1:0]  wr_ptr_reg;
    logic [QD_W-1:0]  wr_ptr_next;
    logic [QD_W-1:0]  rd_ptr_reg;
    logic [QD_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head           = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QD_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QD_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_req;
    end

endmodule

`default_nettype wire

/* rtl/core/gcr_back.sv */
// ----------------------------------------------------------------------------
// gcr_back - window slide and scoreboard update
// Holds window starts and scoreboards; takes one request at a time through calc, shift and apply.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_back
    import gcr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire req_t                head,
    input  wire q_status_t           q_status,
    output logic                     pop,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic                     ba_send,
    output logic [SEQ_W-1:0]         ba_start,
    output logic [BITMAP_W-1:0]      ba_bitmap
);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_CALC  = 4'b0010,
        B_SHIFT = 4'b0100,
        B_APPLY = 4'b1000
    } bstate_t;

    bstate_t state_reg;
    bstate_t state_next;

    logic [SEQ_W-1:0]      start_mem [CONTEXTS];
    logic [RCV_WINDOW-1:0] board_mem [CONTEXTS];

    req_t                  req_reg;
    logic [SEQ_W-1:0]      new_start_reg;
    logic [SEQ_W-1:0]      new_start_next;
    logic                  slide_reg;
    logic                  slide_next;
    logic [AMT_W-1:0]      amount_reg;
    logic [AMT_W-1:0]      amount_next;
    logic [OFF_W-1:0]      offset_reg;
    logic [OFF_W-1:0]      offset_next;
    logic                  in_range_reg;
    logic                  in_range_next;

    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic                  ba_send_reg;
    logic [SEQ_W-1:0]      ba_start_reg;
    logic [SEQ_W-1:0]      ba_start_next;
    logic [BITMAP_W-1:0]   ba_bitmap_reg;
    logic [BITMAP_W-1:0]   ba_bitmap_next;

    logic [SEQ_W-1:0]      cur_start;
    logic [RCV_WINDOW-1:0] cur_board;
    logic [SEQ_W:0]        limit;
    logic                  far;
    logic                  wrap_a;
    logic                  wrap_b;
    logic [SEQ_W-1:0]      far_start;
    logic [SEQ_W-1:0]      eff_start;
    logic signed [SEQ_W:0] diff;
    logic [SEQ_W:0]        off_diff;
    logic [RCV_WINDOW-1:0] shifted;
    logic [RCV_WINDOW-1:0] board_new;
    logic                  bar_hit;

    assign cur_start = start_mem[req_reg.idx];
    assign cur_board = board_mem[req_reg.idx];

    // slide decision
    always_comb
    begin
        limit     = {1'b0, cur_start} + (SEQ_W + 1)'(RCV_WINDOW);
        far       = ({1'b0, req_reg.num} >= limit);
        wrap_a    = (cur_start == SEQ_TOP2) && (req_reg.num < WIN_SEQ);
        wrap_b    = (cur_start == SEQ_TOP1) && (req_reg.num >= WIN_SEQ);
        far_start = (req_reg.num - WIN_SEQ) & ALIGN_MSK;
        slide_next = far || wrap_a || wrap_b;
        if (far)
            new_start_next = far_start;
        else if (wrap_a)
            new_start_next = SEQ_TOP1;
        else if (wrap_b)
            new_start_next = '0;
        else
            new_start_next = cur_start;
    end

    // shift amount and frame offset against the slid window
    always_comb
    begin
        eff_start = new_start_reg;
        diff      = $signed({1'b0, new_start_reg}) - $signed({1'b0, cur_start});
        if (!slide_reg)
            amount_next = '0;
        else if (diff[SEQ_W] || (diff == '0))
            amount_next = AMT_W'(WINDOW);   // rollover: one window
        else if (diff[SEQ_W-1:0] > SEQ_W'(RCV_WINDOW))
            amount_next = AMT_W'(RCV_WINDOW);
        else
            amount_next = diff[AMT_W-1:0];

        off_diff = {1'b0, req_reg.num} - {1'b0, eff_start};
        if ((eff_start == SEQ_TOP1) && (req_reg.num < WIN_SEQ))
        begin
            in_range_next = 1'b1;
            offset_next   = OFF_W'(req_reg.num + WIN_SEQ);
        end
        else
        begin
            in_range_next = !off_diff[SEQ_W] &&
                            (off_diff[SEQ_W-1:0] < SEQ_W'(RCV_WINDOW));
            offset_next   = off_diff[OFF_W-1:0];
        end
    end

    always_comb
    begin
        shifted   = cur_board >> amount_reg;
        board_new = shifted;
        if (in_range_reg)
            board_new = shifted | (RCV_WINDOW'(1) << offset_reg);
        bar_hit = (cur_start == req_reg.num);
    end

    always_comb
    begin
        ba_start_next  = '0;
        ba_bitmap_next = '0;
        case (req_reg.op)
            OP_DATA:     status_next = in_range_reg ? ST_RECORDED : ST_DROPPED;
            OP_CREATE:   status_next = ST_CREATED;
            OP_FULL:     status_next = ST_FULL;
            OP_BAR:
            begin
                status_next = bar_hit ? ST_BA_SENT : ST_BAR_IGNORED;
                if (bar_hit)
                begin
                    ba_start_next  = cur_start;
                    ba_bitmap_next = BITMAP_W'(cur_board[WINDOW-1:0]);
                end
            end
            default:     status_next = ST_BAR_IGNORED;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    state_next = B_CALC;
                end
            end
            B_CALC:  state_next = B_SHIFT;
            B_SHIFT: state_next = B_APPLY;
            B_APPLY:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    state_next = B_CALC;
                end
                else
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == B_APPLY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            req_reg <= head;
        if (state_reg == B_CALC)
        begin
            new_start_reg <= new_start_next;
            slide_reg     <= slide_next;
        end
        if (state_reg == B_SHIFT)
        begin
            amount_reg   <= amount_next;
            offset_reg   <= offset_next;
            in_range_reg <= in_range_next;
        end
        if (state_reg == B_APPLY)
        begin
            status_reg    <= status_next;
            ba_send_reg   <= (status_next == ST_BA_SENT);
            ba_start_reg  <= ba_start_next;
            ba_bitmap_reg <= ba_bitmap_next;
            if (req_reg.op == OP_DATA)
            begin
                start_mem[req_reg.idx] <= new_start_reg;
                board_mem[req_reg.idx] <= board_new;
            end
            else if (req_reg.op == OP_CREATE)
            begin
                start_mem[req_reg.idx] <= req_reg.num & ALIGN_MSK;
                board_mem[req_reg.idx] <= '0;
            end
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign ba_send   = ba_send_reg;
    assign ba_start  = ba_start_reg;
    assign ba_bitmap = ba_bitmap_reg;

endmodule

`default_nettype wire

/* rtl/core/gcr_receive_scoreboard.sv */
// ----------------------------------------------------------------------------
// gcr_receive_scoreboard - group-addressed block ack receive scoreboard
// Per-source receive contexts with sliding scoreboards and BAR response.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  request   | start / busy         | cmd, src_addr, seq_num, bar_start
//  result    | done (one cycle)     | status, ba_send, ba_start, ba_bitmap
//
//  The front end looks the source up and classifies a request in the cycle
//  it is taken, so requests enter one per cycle until the 2-deep queue fills.
//  The back end takes each request through read and slide decision, shift
//  amount and offset, and scoreboard write, and pops the next only in the
//  write step; this loop sets the sustained request rate. The result is
//  registered in the write step. Reset clears all context valid bits at once;
//  no clearing pass. Results cannot be stalled; busy reflects queue full.
//
`default_nettype none

module gcr_receive_scoreboard
    import gcr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                cmd,
    input  wire logic [ADDR_W-1:0]   src_addr,
    input  wire logic [SEQ_W-1:0]    seq_num,
    input  wire logic [SEQ_W-1:0]    bar_start,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic                     ba_send,
    output logic [SEQ_W-1:0]         ba_start,
    output logic [BITMAP_W-1:0]      ba_bitmap
);

    // front to queue
    logic      push;
    req_t      push_req;

    // queue to back
    req_t      head;
    logic      pop;
    q_status_t q_status;

    // source CAM and allocation; the context owner for valid/source
    gcr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .src_addr  (src_addr),
        .seq_num   (seq_num),
        .bar_start (bar_start),
        .q_status  (q_status),
        .busy      (busy),
        .push      (push),
        .push_req  (push_req)
    );

    // keeps request order between the two halves
    gcr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    // window slide, bit record and block ack generation
    gcr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .done      (done),
        .status    (status),
        .ba_send   (ba_send),
        .ba_start  (ba_start),
        .ba_bitmap (ba_bitmap)
    );

endmodule

`default_nettype wire
